// ===== design/iwei_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwei_pkg
// Shared types and constants of the inertial sample window extractor.
// ----------------------------------------------------------------------------
package iwei_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_AXES    = 6;
  localparam int AXIS_W      = $clog2(NUM_AXES);
  // the interpolation quotient is smaller in magnitude than the axis difference
  localparam int QUO_W       = 17;
  localparam int DIV_CNT_W   = $clog2(QUO_W);

  typedef enum logic {
    REQ_PUSH   = 1'b0,
    REQ_WINDOW = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_READY  = 2'd1,
    ST_BAD_WINDOW = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_e;

  // v: acc x, y, z then gyr x, y, z
  typedef struct packed {
    logic [31:0]                t;
    logic [NUM_AXES-1:0][15:0]  v;
  } sample_t;

endpackage

// ===== design/iwei_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwei_cell
// One queue slot: loads a pushed sample or takes the word of its neighbour.
// ----------------------------------------------------------------------------
module iwei_cell (
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic             write_i,
  input  iwei_pkg::sample_t wdata_i,
  input  iwei_pkg::sample_t next_i,
  output iwei_pkg::sample_t data_o
);
  import iwei_pkg::*;

  sample_t data_q, data_d;

  // load on push, advance towards the head on pop, else hold
  always_comb begin
    if (write_i) begin
      data_d = wdata_i;
    end else if (shift_i) begin
      data_d = next_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== design/iwei_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwei_interp
// Linear interpolation of the six axes with one shared multiplier and a
// bit-serial divider; quotient truncated toward zero.
// ----------------------------------------------------------------------------
module iwei_interp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  iwei_pkg::sample_t                    prev_i,
  input  iwei_pkg::sample_t                    next_i,
  input  logic [31:0]                          end_i,
  output logic                                 done_o,
  output logic [iwei_pkg::NUM_AXES-1:0][15:0]  result_o
);
  import iwei_pkg::*;

  typedef enum logic [2:0] {
    IP_IDLE, IP_MUL, IP_ABS, IP_DIV, IP_ACC
  } ip_state_e;

  ip_state_e                 state_q;
  logic [AXIS_W-1:0]         axis_q;
  logic [DIV_CNT_W-1:0]      cnt_q;
  logic signed [49:0]        prod_q;
  logic                      neg_q;
  logic [31:0]               rem_q;
  logic [QUO_W-1:0]          dvd_q;
  logic [QUO_W-1:0]          quo_q;
  logic                      done_q;
  logic [NUM_AXES-1:0][15:0] res_q;

  logic [31:0]        num;
  logic [31:0]        den;
  logic signed [16:0] diff;
  logic signed [49:0] prod_d;
  logic [49:0]        mag;
  logic [33:0]        trial;
  logic [QUO_W-1:0]   quo_s;

  // distance to the end time and span between the two samples
  assign num  = end_i - prev_i.t;
  assign den  = next_i.t - prev_i.t;
  assign diff = $signed({next_i.v[axis_q][15], next_i.v[axis_q]})
              - $signed({prev_i.v[axis_q][15], prev_i.v[axis_q]});
  assign prod_d = diff * $signed({1'b0, num});
  assign mag    = prod_q[49] ? 50'(-prod_q) : 50'(prod_q);
  assign trial  = {1'b0, rem_q, dvd_q[QUO_W-1]} - {2'b00, den};
  assign quo_s  = neg_q ? QUO_W'(-quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IP_IDLE;
      axis_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        IP_IDLE: begin
          if (start_i) begin
            axis_q  <= '0;
            state_q <= IP_MUL;
          end
        end
        IP_MUL: begin
          prod_q  <= prod_d;
          state_q <= IP_ABS;
        end
        // split magnitude: the upper part is already below the divisor
        IP_ABS: begin
          neg_q   <= prod_q[49];
          rem_q   <= mag[48:QUO_W];
          dvd_q   <= mag[QUO_W-1:0];
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= IP_DIV;
        end
        // one quotient bit per cycle
        IP_DIV: begin
          if (!trial[33]) begin
            rem_q <= trial[31:0];
          end else begin
            rem_q <= {rem_q[30:0], dvd_q[QUO_W-1]};
          end
          quo_q <= {quo_q[QUO_W-2:0], ~trial[33]};
          dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
            state_q <= IP_ACC;
          end
        end
        IP_ACC: begin
          res_q[axis_q] <= prev_i.v[axis_q] + quo_s[15:0];
          if (axis_q == AXIS_W'(NUM_AXES - 1)) begin
            done_q  <= 1'b1;
            state_q <= IP_IDLE;
          end else begin
            axis_q  <= axis_q + 1'b1;
            state_q <= IP_MUL;
          end
        end
        default: state_q <= IP_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== design/imu_window_extract_interpolate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_window_extract_interpolate
// Queue of timestamped six-axis samples with window extraction and
// interpolation of the closing sample.
// ----------------------------------------------------------------------------
// A push word gives no result unless the queue is full. A window request is
// checked, then discards the samples up to the window start (keeping at least
// one), emits the samples before the window end and finishes with the closing
// sample; an interpolated closing sample runs the six axes in turn on the
// shared unit (a multiply, a sign step, 17 divider steps and an accumulate for
// each), then hands the result back. Output stalls can hold the sequence.
// Words are taken one at a time; the queue is a row of 32 slots that shift
// towards the head on each pop.
module imu_window_extract_interpolate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] sample_time_i,
  input  logic [15:0] in_acc_x_i,
  input  logic [15:0] in_acc_y_i,
  input  logic [15:0] in_acc_z_i,
  input  logic [15:0] in_gyr_x_i,
  input  logic [15:0] in_gyr_y_i,
  input  logic [15:0] in_gyr_z_i,
  input  logic [31:0] window_start_i,
  input  logic [31:0] window_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_time_o,
  output logic [15:0] out_acc_x_o,
  output logic [15:0] out_acc_y_o,
  output logic [15:0] out_acc_z_o,
  output logic [15:0] out_gyr_x_o,
  output logic [15:0] out_gyr_y_o,
  output logic [15:0] out_gyr_z_o,
  output logic        last_of_run_o,
  output logic [1:0]  status_o
);
  import iwei_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISCARD, S_EMIT, S_CLOSE, S_INTERP, S_FINISH
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  fill_q;
  logic [31:0]       newest_t_q;
  logic [31:0]       start_q;
  logic [31:0]       end_q;
  logic              emitted_q;
  sample_t           prev_q;
  logic              out_valid_q;
  sample_t           out_sample_q;
  logic              out_last_q;
  status_e           out_status_q;

  sample_t                   cell_data [QUEUE_DEPTH];
  sample_t                   front;
  sample_t                   push_sample;
  sample_t                   closing;
  logic                      out_free;
  logic                      in_accept;
  logic                      pop;
  logic                      push_wr;
  logic                      ip_start;
  logic                      ip_done;
  logic [NUM_AXES-1:0][15:0] ip_result;

  assign front    = cell_data[0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign push_sample.t    = sample_time_i;
  assign push_sample.v[0] = in_acc_x_i;
  assign push_sample.v[1] = in_acc_y_i;
  assign push_sample.v[2] = in_acc_z_i;
  assign push_sample.v[3] = in_gyr_x_i;
  assign push_sample.v[4] = in_gyr_y_i;
  assign push_sample.v[5] = in_gyr_z_i;

  assign closing.t = end_q;
  assign closing.v = (state_q == S_FINISH) ? ip_result : front.v;

  // queue control: write at the tail, pop from the head
  always_comb begin
    push_wr  = in_accept && (req_type_i == REQ_PUSH) && (fill_q != CNT_W'(QUEUE_DEPTH));
    pop      = 1'b0;
    ip_start = 1'b0;
    case (state_q)
      S_DISCARD: pop = (fill_q > CNT_W'(1)) && (front.t <= start_q);
      S_EMIT:    pop = (fill_q > CNT_W'(1)) && (front.t < end_q) && out_free;
      S_CLOSE:   ip_start = emitted_q && (front.t != end_q);
      default:   ;
    endcase
  end

  // row of queue slots
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    iwei_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (pop),
      .write_i (push_wr && (fill_q == CNT_W'(i))),
      .wdata_i (push_sample),
      .next_i  ((i < QUEUE_DEPTH - 1) ? cell_data[(i + 1) % QUEUE_DEPTH] : cell_data[i]),
      .data_o  (cell_data[i])
    );
  end

  iwei_interp u_interp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ip_start),
    .prev_i   (prev_q),
    .next_i   (front),
    .end_i    (end_q),
    .done_o   (ip_done),
    .result_o (ip_result)
  );

  // sequencer and output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      emitted_q   <= 1'b0;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
    end else begin
      if (out_free) begin
        out_valid_q <= 1'b0;
      end
      if (pop) begin
        fill_q <= fill_q - 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (req_type_i == REQ_PUSH) begin
              if (push_wr) begin
                fill_q     <= fill_q + 1'b1;
                newest_t_q <= sample_time_i;
              end else begin
                out_valid_q  <= 1'b1;
                out_sample_q <= '0;
                out_last_q   <= 1'b1;
                out_status_q <= ST_OVERFLOW;
              end
            end else if (window_end_i <= window_start_i) begin
              out_valid_q  <= 1'b1;
              out_sample_q <= '0;
              out_last_q   <= 1'b1;
              out_status_q <= ST_BAD_WINDOW;
            end else if (fill_q == '0 || newest_t_q < window_end_i) begin
              out_valid_q  <= 1'b1;
              out_sample_q <= '0;
              out_last_q   <= 1'b1;
              out_status_q <= ST_NOT_READY;
            end else begin
              start_q   <= window_start_i;
              end_q     <= window_end_i;
              emitted_q <= 1'b0;
              state_q   <= S_DISCARD;
            end
          end
        end
        S_DISCARD: begin
          if (!pop) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (pop) begin
            out_valid_q  <= 1'b1;
            out_sample_q <= front;
            out_last_q   <= 1'b0;
            out_status_q <= ST_OK;
            prev_q       <= front;
            emitted_q    <= 1'b1;
          end else if ((fill_q == CNT_W'(1)) || (front.t >= end_q)) begin
            state_q <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          if (ip_start) begin
            state_q <= S_INTERP;
          end else if (out_free) begin
            out_valid_q  <= 1'b1;
            out_sample_q <= closing;
            out_last_q   <= 1'b1;
            out_status_q <= ST_OK;
            prev_q       <= closing;
            state_q      <= S_IDLE;
          end
        end
        S_INTERP: begin
          if (ip_done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_sample_q <= closing;
            out_last_q   <= 1'b1;
            out_status_q <= ST_OK;
            prev_q       <= closing;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_time_o    = out_sample_q.t;
  assign out_acc_x_o   = out_sample_q.v[0];
  assign out_acc_y_o   = out_sample_q.v[1];
  assign out_acc_z_o   = out_sample_q.v[2];
  assign out_gyr_x_o   = out_sample_q.v[3];
  assign out_gyr_y_o   = out_sample_q.v[4];
  assign out_gyr_z_o   = out_sample_q.v[5];
  assign last_of_run_o = out_last_q;
  assign status_o      = out_status_q;

endmodule

// ===== design/iwei_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwei_checker
// Port-level checks of the window extractor, bound to the top level.
// ----------------------------------------------------------------------------
module iwei_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] out_time_o,
  input logic [15:0] out_acc_x_o,
  input logic [15:0] out_gyr_z_o,
  input logic        last_of_run_o,
  input logic [1:0]  status_o
);
  import iwei_pkg::*;

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_time_o)
      && $stable(status_o))
    else $error("stalled output word changed");

  // a status word always closes its run
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_of_run_o)
    else $error("status word without last_of_run");

  // a status word carries a zero sample
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
      (out_time_o == '0) && (out_acc_x_o == '0) && (out_gyr_z_o == '0))
    else $error("status word with non-zero sample");

  // no input word is taken while a stalled output word waits
  a_no_take_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output blocked");

endmodule

bind imu_window_extract_interpolate iwei_checker u_iwei_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_time_o    (out_time_o),
  .out_acc_x_o   (out_acc_x_o),
  .out_gyr_z_o   (out_gyr_z_o),
  .last_of_run_o (last_of_run_o),
  .status_o      (status_o)
);
